[src/lbs_pkg.sv]
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants for the linear blend skinning engine.
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam int MAX_BONES  = 256;
    localparam int INFLUENCES = 4;
    localparam int ELEMS      = 16;
    localparam int BONE_AW    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_SKIN = 1'b1
    } t_cmd;

    typedef logic [ELEMS-1:0][31:0] t_mat;

    typedef struct packed {
        logic en;
    } t_ctl;

endpackage

[src/lbs_palette.sv]
// ----------------------------------------------------------------------------
// lbs_palette
// One copy of the bone palette: element-wide write, whole-matrix registered read.
// ----------------------------------------------------------------------------
module lbs_palette import lbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [7:0]  i_wr_bone,
    input  logic [3:0]  i_wr_elem,
    input  logic [31:0] i_wr_data,
    input  logic        i_rd_en,
    input  logic [7:0]  i_rd_bone,
    output t_mat        o_rd_mat
);

    t_mat mem [MAX_BONES];
    t_mat r_mat;
    logic r_hit;

    always_ff @(posedge i_clk) begin
        if (i_we && ({1'b0, i_wr_bone} < 9'(MAX_BONES))) begin
            mem[i_wr_bone[BONE_AW-1:0]][i_wr_elem] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_mat <= mem[i_rd_bone[BONE_AW-1:0]];
            r_hit <= ({1'b0, i_rd_bone} < 9'(MAX_BONES));
        end
    end

    assign o_rd_mat = r_hit ? r_mat : '0;

endmodule

[src/lbs_datapath.sv]
// ----------------------------------------------------------------------------
// lbs_datapath
// Transform/weight/accumulate pipeline for one vertex per cycle while enabled.
// ----------------------------------------------------------------------------
module lbs_datapath import lbs_pkg::*; (
    input  logic        i_clk,
    input  t_ctl        i_ctl,
    input  t_mat        i_mat [INFLUENCES],
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [63:0] i_weights,
    output logic [31:0] o_x,
    output logic [31:0] o_y,
    output logic [31:0] o_z
);

    logic signed [31:0] pos [3];
    logic [63:0]        r_w0, r_w1;
    logic signed [63:0] r_prod [INFLUENCES][3][3];
    logic signed [31:0] r_trans [INFLUENCES][3];
    logic signed [31:0] r_t [INFLUENCES][3];
    logic signed [48:0] r_tw [3][INFLUENCES];
    logic signed [50:0] r_acc [3];
    logic [31:0]        r_out [3];

    logic signed [49:0] n_sum [INFLUENCES][3];
    logic signed [35:0] n_sh  [3];

    assign pos[0] = i_pos_x;
    assign pos[1] = i_pos_y;
    assign pos[2] = i_pos_z;

    always_comb begin
        for (int i = 0; i < INFLUENCES; i++) begin
            for (int r = 0; r < 3; r++) begin
                n_sum[i][r] = 50'(r_prod[i][r][0] >>> 16) + 50'(r_prod[i][r][1] >>> 16)
                            + 50'(r_prod[i][r][2] >>> 16) + 50'(r_trans[i][r]);
            end
        end
        for (int r = 0; r < 3; r++) begin
            n_sh[r] = 36'(r_acc[r] >>> 15);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_w0     <= i_weights;
            r_w1     <= r_w0;
            for (int i = 0; i < INFLUENCES; i++) begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        r_prod[i][r][c] <= $signed(i_mat[i][c*4+r]) * pos[c];
                    end
                    r_trans[i][r] <= $signed(i_mat[i][12+r]);
                    if (n_sum[i][r] > 50'sd2147483647) begin
                        r_t[i][r] <= 32'sh7FFFFFFF;
                    end else if (n_sum[i][r] < -50'sd2147483648) begin
                        r_t[i][r] <= 32'sh80000000;
                    end else begin
                        r_t[i][r] <= n_sum[i][r][31:0];
                    end
                    r_tw[r][i] <= r_t[i][r] * $signed({1'b0, r_w1[16*i +: 16]});
                end
            end
            for (int r = 0; r < 3; r++) begin
                r_acc[r] <= 51'(r_tw[r][0]) + 51'(r_tw[r][1])
                          + 51'(r_tw[r][2]) + 51'(r_tw[r][3]);
                if (n_sh[r] > 36'sd2147483647) begin
                    r_out[r] <= 32'h7FFFFFFF;
                end else if (n_sh[r] < -36'sd2147483648) begin
                    r_out[r] <= 32'h80000000;
                end else begin
                    r_out[r] <= n_sh[r][31:0];
                end
            end
        end
    end

    assign o_x = r_out[0];
    assign o_y = r_out[1];
    assign o_z = r_out[2];

endmodule

[src/linear_blend_skinning_top.sv]
// ----------------------------------------------------------------------------
// linear_blend_skinning_top
// Four-influence linear blend skinning engine with an on-chip bone palette.
// ----------------------------------------------------------------------------
// The engine takes one transfer per cycle, load or skin, while not stalled.
// A skin passes the palette and input, product, transform, weighted-term,
// accumulator and output registers. Each influence has its own copy of the
// palette so that all four matrices are read in the same cycle; a load
// writes all copies. A load may be followed at once by a skin that uses it.
// The whole pipeline holds while a finished result waits to be taken.
module linear_blend_skinning_top import lbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_palette_entry,
    input  logic [3:0]  i_matrix_element,
    input  logic [31:0] i_element_value,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_blend_indices,
    input  logic [63:0] i_blend_weights,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] n_v;
    t_ctl              ctl;
    logic              accept;
    logic              load;
    logic [31:0]       r_px, r_py, r_pz;
    logic [63:0]       r_wt;
    t_mat              mats [INFLUENCES];

    assign ctl.en     = !r_v[STAGES-1] || i_out_ready;
    assign o_in_ready = ctl.en;
    assign accept     = i_in_valid && ctl.en;
    assign load       = accept && (t_cmd'(i_command) == CMD_LOAD);

    always_comb begin
        n_v = {r_v[STAGES-2:0], accept && (t_cmd'(i_command) == CMD_SKIN)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (ctl.en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_pz <= i_pos_z;
            r_wt <= i_blend_weights;
        end
    end

    for (genvar g = 0; g < INFLUENCES; g++) begin : g_pal
        lbs_palette u_pal (
            .i_clk     (i_clk),
            .i_we      (load),
            .i_wr_bone (i_palette_entry),
            .i_wr_elem (i_matrix_element),
            .i_wr_data (i_element_value),
            .i_rd_en   (ctl.en),
            .i_rd_bone (i_blend_indices[8*g +: 8]),
            .o_rd_mat  (mats[g])
        );
    end

    lbs_datapath u_dp (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_mat     (mats),
        .i_pos_x   (r_px),
        .i_pos_y   (r_py),
        .i_pos_z   (r_pz),
        .i_weights (r_wt),
        .o_x       (o_out_x),
        .o_y       (o_out_y),
        .o_z       (o_out_z)
    );

    assign o_out_valid = r_v[STAGES-1];

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> !r_v[0])
        else $error("load transfer entered the pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ctl.en |=> $stable(r_v))
        else $error("pipeline moved while stalled");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

endmodule

[bench/tb_linear_blend_skinning_top.sv]
// ----------------------------------------------------------------------------
// tb_linear_blend_skinning_top
// Self-checking regression for the four-influence skinning engine.
// ----------------------------------------------------------------------------
// Palette loads and skin transfers are queued by a stimulus process and sent
// by a driver with random gaps, whilst the result side stalls at random. Each
// accepted load updates a local palette copy and each accepted skin predicts
// the saturated position, which is checked against the results in order.
// Skins only use bones whose sixteen elements have all been loaded.
// ----------------------------------------------------------------------------
module tb_linear_blend_skinning_top;
    import lbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_cmd        cmd;
        logic [7:0]  entry;
        logic [3:0]  elem;
        logic [31:0] val;
        logic [31:0] px, py, pz;
        logic [31:0] idx;
        logic [63:0] wts;
    } t_item;

    typedef struct {
        logic [31:0] x, y, z;
    } t_pos;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_command = 1'b0;
    logic [7:0]  i_palette_entry = '0;
    logic [3:0]  i_matrix_element = '0;
    logic [31:0] i_element_value = '0;
    logic [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [31:0] i_blend_indices = '0;
    logic [63:0] i_blend_weights = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_out_x, o_out_y, o_out_z;

    t_item       pending_items[$];
    t_pos        expected_positions[$];
    logic [31:0] palette_copy[MAX_BONES*ELEMS];
    bit          loaded[MAX_BONES*ELEMS];
    int          full_bones[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          queued_count = 0;
    int          accepted_count = 0;
    bit          in_taken = 1'b0;
    bit          running = 1'b0;

    linear_blend_skinning_top uut (.*);

    always #10 i_clk = ~i_clk;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_pos skin_position(t_item it);
        longint p[3];
        longint acc[3];
        longint t, w, m;
        int     bone;
        t_pos   res;
        p[0] = longint'(int'(it.px));
        p[1] = longint'(int'(it.py));
        p[2] = longint'(int'(it.pz));
        acc = '{0, 0, 0};
        for (int i = 0; i < INFLUENCES; i++) begin
            bone = it.idx[8*i +: 8];
            w = longint'({48'b0, it.wts[16*i +: 16]});
            for (int r = 0; r < 3; r++) begin
                t = longint'(int'(palette_copy[bone*ELEMS + 12 + r]));
                for (int c = 0; c < 3; c++) begin
                    m = longint'(int'(palette_copy[bone*ELEMS + c*4 + r]));
                    t += (m * p[c]) >>> 16;
                end
                acc[r] += sat32(t) * w;
            end
        end
        res.x = 32'(sat32(acc[0] >>> 15));
        res.y = 32'(sat32(acc[1] >>> 15));
        res.z = 32'(sat32(acc[2] >>> 15));
        return res;
    endfunction

    function automatic logic [31:0] pick_value(bit narrow);
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return narrow ? 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000)
                                   : $urandom();
        endcase
    endfunction

    task automatic queue_load(int bone, int e, logic [31:0] v);
        t_item it;
        it = '{cmd: CMD_LOAD, entry: bone[7:0], elem: e[3:0], val: v,
               px: $urandom(), py: $urandom(), pz: $urandom(), idx: $urandom(),
               wts: {$urandom(), $urandom()}};
        pending_items = {pending_items, it};
        queued_count++;
        if (!loaded[bone*ELEMS + e]) begin
            loaded[bone*ELEMS + e] = 1'b1;
            for (int k = 0; k < ELEMS; k++) if (!loaded[bone*ELEMS + k]) return;
            full_bones = {full_bones, bone};
        end
    endtask

    task automatic queue_skin(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [31:0] idx, logic [63:0] wts);
        t_item it;
        it = '{cmd: CMD_SKIN, entry: 8'($urandom()), elem: 4'($urandom()), val: $urandom(),
               px: px, py: py, pz: pz, idx: idx, wts: wts};
        pending_items = {pending_items, it};
        queued_count++;
    endtask

    task automatic queue_random_skin();
        logic [31:0] idx;
        logic [63:0] wts;
        for (int i = 0; i < INFLUENCES; i++) begin
            idx[8*i +: 8] = 8'(full_bones[$urandom_range(0, full_bones.size() - 1)]);
            case ($urandom_range(0, 3))
                0: wts[16*i +: 16] = 16'h8000;
                1: wts[16*i +: 16] = 16'($urandom_range(0, 16'hFFFF));
                default: wts[16*i +: 16] = 16'($urandom_range(0, 16'h2000));
            endcase
        end
        queue_skin(pick_value(1), pick_value(1), pick_value(1), idx, wts);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic drain();
        while (accepted_count != queued_count || expected_positions.size() != 0)
            @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        t_item it;
        if (running) begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (!i_in_valid || in_taken) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    it = pending_items.pop_front();
                    i_in_valid       <= 1'b1;
                    i_command        <= it.cmd;
                    i_palette_entry  <= it.entry;
                    i_matrix_element <= it.elem;
                    i_element_value  <= it.val;
                    i_pos_x          <= it.px;
                    i_pos_y          <= it.py;
                    i_pos_z          <= it.pz;
                    i_blend_indices  <= it.idx;
                    i_blend_weights  <= it.wts;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_item it;
        t_pos  want;
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            accepted_count++;
            if (i_command == CMD_LOAD) begin
                palette_copy[i_palette_entry*ELEMS + i_matrix_element] = i_element_value;
            end else begin
                it = '{cmd: CMD_SKIN, entry: '0, elem: '0, val: '0, px: i_pos_x,
                       py: i_pos_y, pz: i_pos_z, idx: i_blend_indices, wts: i_blend_weights};
                expected_positions = {expected_positions, skin_position(it)};
            end
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_positions.size() == 0) begin
                report_mismatch("unexpected result", o_out_x, 'x);
            end else begin
                want = expected_positions.pop_front();
                if (o_out_x !== want.x) report_mismatch("out_x", o_out_x, want.x);
                if (o_out_y !== want.y) report_mismatch("out_y", o_out_y, want.y);
                if (o_out_z !== want.z) report_mismatch("out_z", o_out_z, want.z);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!running || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 5000) begin
            $display("linear_blend_skinning_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 53, 0, 38};
        recv_pct = '{0, 0, 53, 38};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        running = 1'b1;

        for (int e = 0; e < ELEMS; e++) begin
            queue_load(0, e, (e % 5 == 0) ? 32'h0001_0000 : 32'h0);
            queue_load(255, e, e[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
            queue_load(170, e, $urandom());
        end
        queue_skin(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0, 64'h0000_0000_0000_8000);
        queue_skin(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_skin(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                   64'hFFFF_FFFF_FFFF_FFFF);
        queue_skin(32'hFFFF_FFFF, 32'h1, 32'h0, 32'hFF00_AA00, 64'h8000_0000_8000_0000);
        queue_skin(32'h1234_5678, 32'hFEDC_BA98, 32'h0, 32'hAAFF_00AA, 64'h0);
        queue_skin(32'h0, 32'h0, 32'h0, 32'hFF_AA_00_FF, 64'h0001_7FFF_8000_FFFF);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            for (int n = 0; n < 200; n++) begin
                if ($urandom_range(0, 99) < 3) begin
                    automatic int bone = $urandom_range(0, MAX_BONES - 1);
                    for (int e = 0; e < ELEMS; e++) queue_load(bone, e, pick_value(0));
                end else if ($urandom_range(0, 99) < 25) begin
                    queue_load($urandom_range(0, MAX_BONES - 1), $urandom_range(0, ELEMS - 1),
                               pick_value(0));
                end else begin
                    queue_random_skin();
                end
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_positions.size() == 0)
            $display("linear_blend_skinning_top regression: pass");
        else
            $display("linear_blend_skinning_top regression: fail");
        $finish;
    end
endmodule

[files.f]
src/lbs_pkg.sv
src/lbs_palette.sv
src/lbs_datapath.sv
src/linear_blend_skinning_top.sv
bench/tb_linear_blend_skinning_top.sv
